@@ rtl/core/qtpg_pkg.sv @@
// Package for the trot phase generator: payload structs, register indexes,
// widths and fixed constants. No dependencies.
package qtpg_pkg;

  localparam int PHASE_BITS_DEF = 16;
  localparam int STEP_W         = 10;
  localparam int SWING_W        = 12;
  localparam int STANCE_W       = 20;
  localparam int OUT_W          = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 12;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWING_PERIOD = 2'd1;

  localparam logic [STEP_W-1:0]   STEP_RESET   = 10'd100;
  localparam logic [SWING_W-1:0]  SWING_RESET  = 12'd250;
  localparam logic [STANCE_W-1:0] STANCE_SCALE = 20'd1000;
  localparam logic [STANCE_W-1:0] STANCE_MAX   = 20'hFFFFF;
  localparam logic [OUT_W-1:0]    OUT_MAX      = 16'hFFFF;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] speed_mm_s;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] stance_leg0;
    logic [OUT_W-1:0] stance_leg1;
    logic [OUT_W-1:0] stance_leg2;
    logic [OUT_W-1:0] stance_leg3;
    logic [OUT_W-1:0] swing_leg0;
    logic [OUT_W-1:0] swing_leg1;
    logic [OUT_W-1:0] swing_leg2;
    logic [OUT_W-1:0] swing_leg3;
  } out_t;

  // Status of the shared divider as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/core/qtpg_div.sv @@
// Shared restoring divider for the trot phase generator, one quotient bit
// per cycle. Depends on qtpg_pkg for the status struct.
module qtpg_div #(
  parameter int NUM_W = 36,
  parameter int DEN_W = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [NUM_W-1:0]        num,
  input  logic [DEN_W-1:0]        den,
  output qtpg_pkg::div_stat_t     stat,
  output logic [NUM_W-1:0]        quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem, q[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift the dividend out and the quotient in; remainder stays below divisor
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      dvs <= den;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q   <= {q[NUM_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quo       = q;

endmodule

@@ rtl/core/quadruped_trot_phase_generator.sv @@
// Top level of the trot phase generator: sequencer, gait state and result
// register around one shared divider. Depends on qtpg_pkg and qtpg_div.
//
// Usage: in_data carries a time sample (now_ms, speed_mm_s) on a valid/ready
// channel; out_data returns one result transaction per input transaction with
// the stance and swing phases of all four legs. The cfg channel writes
// step_length_mm (index 0) or swing_period_ms (index 1); other indexes are
// ignored and cfg_ready is always high. Write configuration only while idle.
// A zero speed skips the divider and gives an all-zero result. Otherwise one
// divider pass computes the stance period and at most one pass per leg pair
// computes the phase, each pass yielding STANCE_W + PHASE_BITS quotient bits.
// The block takes one transaction at a time; in_ready is high only when the
// sequencer is idle. A finished result waits in the output register while
// out_ready is low, and the next input may be accepted meanwhile; its result
// is held back until the waiting one is taken.
// Reset loads the register defaults (100 mm, 250 ms), clears the stride
// reference and the started flag, and empties the output register.
module quadruped_trot_phase_generator #(
  parameter int PHASE_BITS = qtpg_pkg::PHASE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  qtpg_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output qtpg_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qtpg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qtpg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SW    = qtpg_pkg::STANCE_W;
  localparam int OW    = qtpg_pkg::OUT_W;
  localparam int NUM_W = SW + PHASE_BITS;
  localparam int DEN_W = SW;
  localparam int CW    = SW + 3;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_STANCE = 3'd1;
  localparam logic [2:0] S_TIME   = 3'd2;
  localparam logic [2:0] S_LEG    = 3'd3;
  localparam logic [2:0] S_LWAIT  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]                      state;
  logic [qtpg_pkg::STEP_W-1:0]     step_len;
  logic [qtpg_pkg::SWING_W-1:0]    swing;
  logic [31:0]                     stride_start;
  logic                            gait_started;
  logic [31:0]                     now;
  logic [SW-1:0]                   stance;
  logic [SW:0]                     stride;
  logic [SW:0]                     elapsed;
  logic                            leg;
  logic                            to_swing;
  logic [OW-1:0]                   st_a, sw_a, st_b, sw_b;

  logic                            div_start;
  logic [NUM_W-1:0]                div_num;
  logic [DEN_W-1:0]                div_den;
  qtpg_pkg::div_stat_t             div_stat;
  logic [NUM_W-1:0]                div_quo;

  logic                            in_acc;
  logic                            out_load;
  logic [SW-1:0]                   prod;
  logic [SW-1:0]                   stance_q;
  logic [OW-1:0]                   phase_q;
  logic [SW-1:0]                   stride_half;
  logic [31:0]                     ref_ms;
  logic [31:0]                     el_full;
  logic signed [CW-1:0]            cs, sum_sw, diff_st;
  logic                            is_st, is_swn, is_swp;
  logic [SW-1:0]                   num_c;

  assign in_ready  = state == S_IDLE;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = state == S_DONE && (!out_valid || out_ready);

  assign prod = SW'(step_len) * qtpg_pkg::STANCE_SCALE;

  assign stance_q = (|div_quo[NUM_W-1:SW]) ? qtpg_pkg::STANCE_MAX : div_quo[SW-1:0];
  assign phase_q  = (|div_quo[NUM_W-1:OW]) ? qtpg_pkg::OUT_MAX : div_quo[OW-1:0];

  assign stride_half = stride[SW:1];
  assign ref_ms      = gait_started ? stride_start : now;
  assign el_full     = now - ref_ms;

  // Leg clock: legs 1 and 2 run half a stride behind legs 0 and 3
  assign cs = leg ? $signed(CW'(elapsed)) - $signed(CW'(stride_half))
                  : $signed(CW'(elapsed));
  assign sum_sw  = cs + $signed(CW'(swing));
  assign diff_st = cs - $signed(CW'(stance));
  assign is_st   = cs > 0 && cs < $signed(CW'(stance));
  assign is_swn  = cs < 0 && sum_sw > 0;
  assign is_swp  = cs > $signed(CW'(stance)) && cs < $signed(CW'(stride));
  assign num_c   = is_st ? cs[SW-1:0] : (is_swn ? sum_sw[SW-1:0] : diff_st[SW-1:0]);

  always_comb begin
    div_start = 1'b0;
    div_num   = NUM_W'(prod);
    div_den   = DEN_W'(in_data.speed_mm_s);
    case (state)
      S_IDLE: begin
        div_start = in_acc && in_data.speed_mm_s != '0;
      end
      S_LEG: begin
        div_start = is_st || is_swn || is_swp;
        div_num   = {num_c, {PHASE_BITS{1'b0}}};
        div_den   = is_st ? stance : DEN_W'(swing);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  qtpg_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step_len <= qtpg_pkg::STEP_RESET;
      swing    <= qtpg_pkg::SWING_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == qtpg_pkg::REG_STEP_LENGTH) begin
        step_len <= cfg_data[qtpg_pkg::STEP_W-1:0];
      end else if (cfg_index == qtpg_pkg::REG_SWING_PERIOD) begin
        swing <= cfg_data[qtpg_pkg::SWING_W-1:0];
      end
    end
  end

  // Sequencer and gait state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stride_start <= '0;
      gait_started <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= (in_data.speed_mm_s == '0) ? S_DONE : S_STANCE;
          end
        end
        S_STANCE: begin
          if (div_stat.done) begin
            state <= S_TIME;
          end
        end
        S_TIME: begin
          gait_started <= 1'b1;
          stride_start <= (el_full > 32'(stride)) ? now : ref_ms;
          state        <= S_LEG;
        end
        S_LEG: begin
          state <= div_start ? S_LWAIT : (leg ? S_DONE : S_LEG);
        end
        S_LWAIT: begin
          if (div_stat.done) begin
            state <= leg ? S_DONE : S_LEG;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          now  <= in_data.now_ms;
          leg  <= 1'b0;
          st_a <= '0;
          sw_a <= '0;
          st_b <= '0;
          sw_b <= '0;
        end
      end
      S_STANCE: begin
        if (div_stat.done) begin
          stance <= stance_q;
          stride <= (SW + 1)'(stance_q) + (SW + 1)'(swing);
        end
      end
      S_TIME: begin
        elapsed <= (el_full > 32'(stride)) ? '0 : el_full[SW:0];
      end
      S_LEG: begin
        to_swing <= !is_st;
        if (!div_start) begin
          leg <= 1'b1;
        end
      end
      S_LWAIT: begin
        if (div_stat.done) begin
          leg <= 1'b1;
          if (!leg) begin
            if (to_swing) sw_a <= phase_q;
            else st_a <= phase_q;
          end else begin
            if (to_swing) sw_b <= phase_q;
            else st_b <= phase_q;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_data.stance_leg0 <= st_a;
          out_data.stance_leg3 <= st_a;
          out_data.swing_leg0  <= sw_a;
          out_data.swing_leg3  <= sw_a;
          out_data.stance_leg1 <= st_b;
          out_data.stance_leg2 <= st_b;
          out_data.swing_leg1  <= sw_b;
          out_data.swing_leg2  <= sw_b;
        end
      end
      default: begin
        leg <= leg;
      end
    endcase
  end

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_leg_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(st_a != '0 && sw_a != '0) && !(st_b != '0 && sw_b != '0))
    else $error("leg in stance and swing at once");

  a_elapsed_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_LEG |-> elapsed <= stride)
    else $error("elapsed time beyond stride");

  a_started_holds: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !$fell(gait_started))
    else $error("gait started flag dropped");

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the trot gait phase generator.
// Predicts all eight leg phases for each time sample in a scoreboard class and
// checks every result transaction. Depends on qtpg_pkg and the top level RTL.
module tb;
  import qtpg_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1_500_000;
  localparam int unsigned END_SLACK    = 300;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  class trot_scoreboard;
    logic [STEP_W-1:0]  step_mm;
    logic [SWING_W-1:0] swing_ms;
    logic [31:0]        stride_origin;
    bit                 gait_on;
    out_t               phases_due[$];
    int unsigned        mismatches;

    function new();
      step_mm       = STEP_RESET;
      swing_ms      = SWING_RESET;
      stride_origin = '0;
      gait_on       = 1'b0;
      mismatches    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_STEP_LENGTH:  step_mm  = data[STEP_W-1:0];
        REG_SWING_PERIOD: swing_ms = data[SWING_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned stance_for(logic [15:0] speed);
      longint unsigned s;
      if (speed == 0) return 0;
      s = (longint'(step_mm) * longint'(STANCE_SCALE)) / speed;
      if (s > longint'(STANCE_MAX)) s = STANCE_MAX;
      return s;
    endfunction

    function logic [OUT_W-1:0] phase_frac(longint unsigned num, longint unsigned den);
      longint unsigned q;
      if (den == 0) return '0;
      q = (num << PHASE_BITS_DEF) / den;
      if (q > longint'(OUT_MAX)) q = OUT_MAX;
      return q[OUT_W-1:0];
    endfunction

    function void leg_phase(longint c, longint stance, longint swing,
                            output logic [OUT_W-1:0] st, output logic [OUT_W-1:0] sw);
      st = (c > 0 && c < stance) ? phase_frac(c, stance) : '0;
      if (c > -swing && c < 0)
        sw = phase_frac(c + swing, swing);
      else if (c > stance && c < stance + swing)
        sw = phase_frac(c - stance, swing);
      else
        sw = '0;
    endfunction

    function void note_input(in_t s);
      out_t             r;
      longint unsigned  stance;
      longint unsigned  stride;
      longint unsigned  elapsed;
      logic [31:0]      delta;
      longint           lag;
      logic [OUT_W-1:0] st0, sw0, st1, sw1;
      r = '0;
      if (s.speed_mm_s != 0) begin
        stance = stance_for(s.speed_mm_s);
        stride = stance + swing_ms;
        if (!gait_on) begin
          gait_on       = 1'b1;
          stride_origin = s.now_ms;
        end
        delta   = s.now_ms - stride_origin;
        elapsed = delta;
        // restart the stride once time runs past its end
        if (elapsed > stride) begin
          stride_origin = s.now_ms;
          elapsed       = 0;
        end
        lag = longint'(elapsed) - longint'(stride >> 1);
        leg_phase(longint'(elapsed), longint'(stance), longint'(swing_ms), st0, sw0);
        leg_phase(lag, longint'(stance), longint'(swing_ms), st1, sw1);
        r.stance_leg0 = st0;
        r.stance_leg3 = st0;
        r.swing_leg0  = sw0;
        r.swing_leg3  = sw0;
        r.stance_leg1 = st1;
        r.stance_leg2 = st1;
        r.swing_leg1  = sw1;
        r.swing_leg2  = sw1;
      end
      phases_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (phases_due.size() == 0) begin
        $error("result transaction with no time sample pending");
        mismatches++;
        return;
      end
      want = phases_due.pop_front();
      compare_field("stance_leg0", want.stance_leg0, got.stance_leg0);
      compare_field("stance_leg1", want.stance_leg1, got.stance_leg1);
      compare_field("stance_leg2", want.stance_leg2, got.stance_leg2);
      compare_field("stance_leg3", want.stance_leg3, got.stance_leg3);
      compare_field("swing_leg0", want.swing_leg0, got.swing_leg0);
      compare_field("swing_leg1", want.swing_leg1, got.swing_leg1);
      compare_field("swing_leg2", want.swing_leg2, got.swing_leg2);
      compare_field("swing_leg3", want.swing_leg3, got.swing_leg3);
    endfunction

    function int unsigned pending();
      return phases_due.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  trot_scoreboard sb;
  bit             steady;
  int unsigned    cycle_count;

  quadruped_trot_phase_generator u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Entered and left at a falling edge; valid stays up between back-to-back samples.
  task automatic send_sample(input logic [31:0] now_val, input logic [15:0] speed);
    int unsigned gap;
    in_t         s;
    gap          = steady ? 0 : $urandom_range(0, 4);
    s.now_ms     = now_val;
    s.speed_mm_s = speed;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_input(s);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    if (last) cfg_valid <= 1'b0;
  endtask

  // Hold the sender until every pending result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly well-formed gait runs: steady speed, time advancing through strides.
  task automatic run_gait_phase(input int unsigned n_items);
    int unsigned     sent;
    int unsigned     run_len;
    int unsigned     sel;
    logic [31:0]     t;
    logic [15:0]     speed;
    longint unsigned stride;
    sent = 0;
    t    = $urandom();
    while (sent < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        send_sample($urandom(), 16'($urandom_range(0, 16'hFFFF)));
        sent++;
      end else begin
        if (sel < 20)
          t = $urandom();
        else if (sel < 25)
          t = 32'hFFFF_FFFF - $urandom_range(0, 2000);
        case ($urandom_range(0, 9))
          0:       speed = 16'($urandom_range(1, 65535));
          1:       speed = 16'($urandom_range(1, 20));
          default: speed = 16'($urandom_range(50, 3000));
        endcase
        stride  = sb.stance_for(speed) + sb.swing_ms;
        run_len = $urandom_range(8, 40);
        repeat (run_len) begin
          if ($urandom_range(0, 19) == 0)
            send_sample(t, '0);
          else
            send_sample(t, speed);
          if ($urandom_range(0, 29) == 0)
            t += 32'(stride) + $urandom_range(1, 1000);
          else
            t += $urandom_range(0, int'(stride / 5) + 2);
        end
        sent += run_len;
      end
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_ready = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : main_seq
    logic [31:0] t;
    sb        = new();
    steady    = 1'b0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_STEP_LENGTH;
    cfg_data  = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed samples at reset settings: stop before the gait starts, start
    // just below the time wrap, walk the stride boundaries, then extreme speeds.
    t = 32'hFFFF_FFF0;
    send_sample(32'h0000_0000, 16'd0);
    send_sample(t, 16'd1000);
    send_sample(t + 40, 16'd1000);
    send_sample(t + 100, 16'd1000);
    send_sample(t + 175, 16'd1000);
    send_sample(t + 276, 16'd1000);
    send_sample(t + 350, 16'd1000);
    send_sample(t + 700, 16'd1000);
    t = t + 700;
    send_sample(t + 1, 16'd0);
    send_sample(t + 1, 16'hFFFF);
    send_sample(t + 2, 16'hFFFF);
    send_sample(t + 3, 16'd1);
    send_sample(t + 60000, 16'd1);
    send_sample(32'hFFFF_FFFF, 16'hFFFF);
    send_sample(32'h8000_0000, 16'h8000);
    send_sample(32'h5555_5555, 16'h5555);
    send_sample(32'hAAAA_AAAA, 16'hAAAA);
    send_sample(32'h0000_0000, 16'd0);
    run_gait_phase(250);

    settle();
    cfg_write(REG_STEP_LENGTH, 12'd1, 1'b0);
    cfg_write(REG_SWING_PERIOD, 12'd1, 1'b1);
    steady = 1'b1;
    run_gait_phase(200);
    steady = 1'b0;

    settle();
    cfg_write(REG_STEP_LENGTH, 12'd1000, 1'b0);
    cfg_write(REG_SWING_PERIOD, 12'd4095, 1'b1);
    run_gait_phase(250);

    // zero step length: no stance phase anywhere
    settle();
    cfg_write(REG_STEP_LENGTH, 12'd0, 1'b0);
    cfg_write(REG_SWING_PERIOD, 12'd250, 1'b1);
    run_gait_phase(200);

    // zero swing period: no swing phase anywhere
    settle();
    cfg_write(REG_STEP_LENGTH, 12'd300, 1'b0);
    cfg_write(REG_SWING_PERIOD, 12'd0, 1'b1);
    run_gait_phase(200);

    // upper data bits drop off the step length register
    settle();
    cfg_write(REG_STEP_LENGTH, 12'hFFF, 1'b0);
    cfg_write(REG_SWING_PERIOD, 12'($urandom_range(1, 4095)), 1'b1);
    run_gait_phase(200);

    // writes to unused indexes must leave both registers alone
    settle();
    cfg_write(REG_SPARE_A, 12'($urandom()), 1'b0);
    cfg_write(REG_STEP_LENGTH, 12'($urandom_range(1, 1000)), 1'b0);
    cfg_write(REG_SPARE_B, 12'($urandom()), 1'b0);
    cfg_write(REG_SWING_PERIOD, 12'($urandom_range(1, 4095)), 1'b1);
    run_gait_phase(300);

    settle();
    cfg_write(REG_STEP_LENGTH, 12'($urandom_range(1, 1000)), 1'b0);
    cfg_write(REG_SPARE_B, 12'hFFF, 1'b0);
    cfg_write(REG_SWING_PERIOD, 12'($urandom_range(1, 600)), 1'b1);
    run_gait_phase(300);

    settle();
    repeat (END_SLACK) @(posedge clk);
    if (sb.mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
